>>> sv/fcpm_pkg.sv
// fcpm_pkg: shared types and codes for the false-color palette map unit
// used by fcpm_map, false_color_palette_map_unit and fcpm_checker; no dependencies
package fcpm_pkg;

  localparam int PIX_W = 8;
  localparam int SEL_W = 4;
  localparam int PACK_W = 16;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // palette codes
  localparam logic [SEL_W-1:0] PAL_INV_SPLIT  = 4'd0;
  localparam logic [SEL_W-1:0] PAL_FOUR_BAND  = 4'd1;
  localparam logic [SEL_W-1:0] PAL_METAL      = 4'd2;
  localparam logic [SEL_W-1:0] PAL_THREE_RAMP = 4'd3;
  localparam logic [SEL_W-1:0] PAL_RBOW_DARK  = 4'd4;
  localparam logic [SEL_W-1:0] PAL_RBOW_BLUE  = 4'd5;
  localparam logic [SEL_W-1:0] PAL_FIVE_STEP  = 4'd6;
  localparam logic [SEL_W-1:0] PAL_CYAN_START = 4'd7;
  localparam logic [SEL_W-1:0] PAL_JET        = 4'd8;
  localparam logic [SEL_W-1:0] PAL_GRAY       = 4'd9;

  // register index, taken from paddr[2]
  localparam logic REG_PALETTE_SELECT = 1'b0;
  localparam logic REG_SWAP_BYTES     = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

endpackage

>>> sv/fcpm_map.sv
// fcpm_map: combinational gray to rgb palette lookup for ten piecewise-linear palettes
// depends on fcpm_pkg
module fcpm_map (
  input  logic [fcpm_pkg::SEL_W-1:0] sel,
  input  logic [fcpm_pkg::PIX_W-1:0] v,
  output fcpm_pkg::rgb_t             color
);

  localparam int RECIP_SH = 24;
  localparam int RECIP_CW = 28;
  // m * ceil(2^24 / d): floor(a*m/d) exact for all operands used here
  localparam logic [RECIP_CW-1:0] K_R_124 = RECIP_CW'(255 * (((1 << RECIP_SH) + 123) / 124));
  localparam logic [RECIP_CW-1:0] K_G_117 = RECIP_CW'(255 * (((1 << RECIP_SH) + 116) / 117));
  localparam logic [RECIP_CW-1:0] K_B_91  = RECIP_CW'(100 * (((1 << RECIP_SH) + 90) / 91));
  localparam logic [RECIP_CW-1:0] K_B_29  = RECIP_CW'(128 * (((1 << RECIP_SH) + 28) / 29));
  localparam logic [RECIP_CW-1:0] K_B_41  = RECIP_CW'(255 * (((1 << RECIP_SH) + 40) / 41));
  localparam logic [RECIP_CW-1:0] K_G_51H = RECIP_CW'(128 * (((1 << RECIP_SH) + 50) / 51));
  localparam logic [RECIP_CW-1:0] K_G_51L = RECIP_CW'(127 * (((1 << RECIP_SH) + 50) / 51));

  function automatic logic [7:0] seg2(input logic [7:0] a, input logic [7:0] m,
                                      input logic [2:0] sh);
    logic [15:0] prod;
    prod = {8'd0, a} * {8'd0, m};
    return 8'(prod >> sh);
  endfunction

  function automatic logic [7:0] segc(input logic [7:0] a, input logic [RECIP_CW-1:0] k);
    logic [RECIP_CW+7:0] prod;
    prod = {{RECIP_CW{1'b0}}, a} * {8'd0, k};
    return prod[RECIP_SH+7:RECIP_SH];
  endfunction

  logic [7:0] rr, gg, bb;
  logic [7:0] v4, v5;

  // 4v and 5v modulo 256
  assign v4 = {v[5:0], 2'b00};
  assign v5 = v + v4;

  always_comb begin
    rr = 8'd0;
    gg = 8'd0;
    bb = 8'd0;
    case (sel)
      fcpm_pkg::PAL_INV_SPLIT: begin
        rr = v;
        gg = (v >= 8'd127) ? v - 8'd127 : 8'd127 - v;
        bb = 8'd255 - v;
      end
      fcpm_pkg::PAL_FOUR_BAND, fcpm_pkg::PAL_CYAN_START: begin
        if (v <= 8'd63) begin
          if (sel == fcpm_pkg::PAL_CYAN_START) begin
            gg = seg2(8'd64 - v, 8'd255, 3'd6);
            bb = 8'd255;
          end else begin
            bb = seg2(v, 8'd255, 3'd6);
          end
        end else if (v <= 8'd127) begin
          gg = seg2(v - 8'd64, 8'd255, 3'd6);
          bb = seg2(8'd127 - v, 8'd255, 3'd6);
        end else if (v <= 8'd191) begin
          rr = seg2(v - 8'd128, 8'd255, 3'd6);
          gg = 8'd255;
        end else begin
          rr = 8'd255;
          gg = seg2(8'd255 - v, 8'd255, 3'd6);
        end
      end
      fcpm_pkg::PAL_METAL: begin
        if (v <= 8'd63) begin
          bb = seg2(v, 8'd255, 3'd6);
        end else if (v <= 8'd95) begin
          rr = seg2(v - 8'd63, 8'd127, 3'd5);
          gg = rr;
          bb = 8'd255;
        end else if (v <= 8'd127) begin
          rr = seg2(v - 8'd95, 8'd127, 3'd5) + 8'd128;
          gg = rr;
          bb = seg2(8'd127 - v, 8'd255, 3'd5);
        end else if (v <= 8'd191) begin
          rr = 8'd255;
          gg = 8'd255;
        end else begin
          rr = 8'd255;
          gg = 8'd255;
          bb = seg2(v - 8'd192, 8'd255, 3'd6);
        end
      end
      fcpm_pkg::PAL_THREE_RAMP: begin
        if (v <= 8'd16) rr = 8'd0;
        else if (v <= 8'd140) rr = segc(v - 8'd16, K_R_124);
        else rr = 8'd255;
        if (v <= 8'd101) gg = 8'd0;
        else if (v <= 8'd218) gg = segc(v - 8'd101, K_G_117);
        else gg = 8'd255;
        // blue stays dark between the two ramps
        if (v <= 8'd91) bb = 8'd28 + segc(v, K_B_91);
        else if (v <= 8'd120) bb = segc(8'd120 - v, K_B_29);
        else if (v <= 8'd214) bb = 8'd0;
        else bb = segc(v - 8'd214, K_B_41);
      end
      fcpm_pkg::PAL_RBOW_DARK, fcpm_pkg::PAL_RBOW_BLUE: begin
        if (v <= 8'd63 && sel == fcpm_pkg::PAL_RBOW_BLUE) begin
          gg = seg2(v, 8'd255, 3'd6);
          bb = 8'd255;
        end else if (v <= 8'd31) begin
          bb = seg2(v, 8'd255, 3'd5);
        end else if (v <= 8'd63) begin
          gg = seg2(v - 8'd32, 8'd255, 3'd5);
          bb = 8'd255;
        end else if (v <= 8'd95) begin
          gg = 8'd255;
          bb = seg2(8'd95 - v, 8'd255, 3'd5);
        end else if (v <= 8'd127) begin
          rr = seg2(v - 8'd96, 8'd255, 3'd5);
          gg = 8'd255;
        end else if (v <= 8'd191) begin
          rr = 8'd255;
          gg = seg2(8'd191 - v, 8'd255, 3'd6);
        end else begin
          rr = 8'd255;
          gg = seg2(v - 8'd192, 8'd255, 3'd6);
          bb = gg;
        end
      end
      fcpm_pkg::PAL_FIVE_STEP: begin
        if (v <= 8'd51) begin
          gg = v5;
          bb = 8'd255;
        end else if (v <= 8'd102) begin
          gg = 8'd255;
          bb = 8'd254 - v5;
        end else if (v <= 8'd153) begin
          rr = v5 + 8'd2;
          gg = 8'd255;
        end else if (v <= 8'd204) begin
          rr = 8'd255;
          gg = 8'd255 - segc(v - 8'd153, K_G_51H);
        end else begin
          rr = 8'd255;
          gg = 8'd127 - segc(v - 8'd204, K_G_51L);
        end
      end
      fcpm_pkg::PAL_JET: begin
        // offsets 254, 510 and 1022 taken modulo 256
        if (v <= 8'd63) begin
          gg = 8'd254 - v4;
          bb = 8'd255;
        end else if (v <= 8'd127) begin
          gg = v4 + 8'd2;
          bb = 8'd254 - v4;
        end else if (v <= 8'd191) begin
          rr = v4 + 8'd2;
          gg = 8'd255;
        end else begin
          rr = 8'd255;
          gg = 8'd254 - v4;
        end
      end
      fcpm_pkg::PAL_GRAY: begin
        rr = v;
        gg = v;
        bb = v;
      end
      default: begin
        rr = 8'd0;
        gg = 8'd0;
        bb = 8'd0;
      end
    endcase
  end

  assign color.red   = rr;
  assign color.green = gg;
  assign color.blue  = bb;

endmodule

>>> sv/false_color_palette_map_unit.sv
// false_color_palette_map_unit: top level, pixel registers, rgb565 packing and apb registers
// depends on fcpm_pkg and fcpm_map
//
// One gray pixel is taken on every clock where start is high; busy is always low, so a pixel
// can be offered in every cycle. Its color appears on red, green, blue and rgb565 for a single
// cycle, marked by done; the receiver cannot hold it off. The rate of one pixel per clock and
// the path from input to output come from the input register, one pass through the palette
// logic and the result register. palette_select sits at address 0x0 (reset 9, plain gray,
// codes 10 to 15 give black) and swap_bytes at 0x4 (reset 0); change them only while no
// pixel is in flight.
module false_color_palette_map_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [fcpm_pkg::PIX_W-1:0]   gray,
  output logic                         done,
  output logic [fcpm_pkg::PIX_W-1:0]   red,
  output logic [fcpm_pkg::PIX_W-1:0]   green,
  output logic [fcpm_pkg::PIX_W-1:0]   blue,
  output logic [fcpm_pkg::PACK_W-1:0]  rgb565,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fcpm_pkg::APB_AW-1:0]  paddr,
  input  logic [fcpm_pkg::APB_DW-1:0]  pwdata,
  output logic [fcpm_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  logic [fcpm_pkg::SEL_W-1:0]  palette_select;
  logic                        swap_bytes;
  logic                        in_vld;
  logic [fcpm_pkg::PIX_W-1:0]  gray_q;
  fcpm_pkg::rgb_t              color;
  logic [fcpm_pkg::PACK_W-1:0] pack;
  logic [fcpm_pkg::PACK_W-1:0] pack_next;
  logic                        wr_en;
  logic                        reg_idx;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_select <= fcpm_pkg::PAL_GRAY;
      swap_bytes     <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        fcpm_pkg::REG_PALETTE_SELECT: palette_select <= pwdata[fcpm_pkg::SEL_W-1:0];
        fcpm_pkg::REG_SWAP_BYTES:     swap_bytes     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fcpm_pkg::REG_PALETTE_SELECT:
        prdata = {{(fcpm_pkg::APB_DW-fcpm_pkg::SEL_W){1'b0}}, palette_select};
      fcpm_pkg::REG_SWAP_BYTES: prdata = {{(fcpm_pkg::APB_DW-1){1'b0}}, swap_bytes};
      default: prdata = '0;
    endcase
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      gray_q <= gray;
    end
  end

  fcpm_map u_map (
    .sel   (palette_select),
    .v     (gray_q),
    .color (color)
  );

  assign pack = {color.red[7:3], color.green[7:2], color.blue[7:3]};
  assign pack_next = swap_bytes ? {pack[7:0], pack[15:8]} : pack;

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      red    <= color.red;
      green  <= color.green;
      blue   <= color.blue;
      rgb565 <= pack_next;
    end
  end

endmodule

>>> sv/fcpm_checker.sv
// fcpm_port_checker: port-level assertions for false_color_palette_map_unit, with its bind
// depends on fcpm_pkg and the top level's ports
module fcpm_port_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [fcpm_pkg::PIX_W-1:0]   red,
  input logic [fcpm_pkg::PIX_W-1:0]   green,
  input logic [fcpm_pkg::PIX_W-1:0]   blue,
  input logic [fcpm_pkg::PACK_W-1:0]  rgb565
);

  logic [fcpm_pkg::PACK_W-1:0] pack_plain;

  assign pack_plain = {red[7:3], green[7:2], blue[7:3]};

  // every accepted item gives a result, marked by done
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("accepted item gave no result");

  // no result without an accepted item
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  // packed word agrees with the color, plain or byte-swapped
  a_pack_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (rgb565 == pack_plain ||
              rgb565 == {pack_plain[7:0], pack_plain[15:8]}))
    else $error("rgb565 does not match color");

  // nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result right after reset");

endmodule

bind false_color_palette_map_unit fcpm_port_checker u_checker (.*);
